// File: rtl/cowa_pkg.sv
// ----------------------------------------------------------------------------
// cowa_pkg: shared types and constants of the CNN output write-back addresser
// Lane geometry, register indexes, configuration and per-vector job records.
// ----------------------------------------------------------------------------
package cowa_pkg;

  localparam int LANES     = 8;   // lane values per input vector
  localparam int VECTOR    = 8;   // vector size of the vector-interleaved layout
  localparam int DATA_BITS = 8;   // bits of one lane value

  localparam int LANE_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int OFF_SPAN = (LANES > VECTOR) ? LANES : VECTOR;
  localparam int OFF_W    = (OFF_SPAN > 1) ? $clog2(OFF_SPAN) : 1;
  localparam int GRP_W    = 12;
  localparam int ADDR_W   = 32;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH_COLS    = 4'd0,
    REG_HEIGHT_ROWS   = 4'd1,
    REG_CHANNEL_COUNT = 4'd2,
    REG_CHANNEL_PAD   = 4'd3,
    REG_ROW_PITCH     = 4'd4,
    REG_PLANE_PITCH   = 4'd5,
    REG_BATCH_BASE    = 4'd6,
    REG_POOL_LAYOUT   = 4'd7
  } cfg_reg_t;

  typedef logic [LANES-1:0][DATA_BITS-1:0] lanes_t;

  typedef struct packed {
    logic [7:0]        width_cols;
    logic [7:0]        height_rows;
    logic [11:0]       channel_count;
    logic [7:0]        channel_pad;
    logic [15:0]       row_pitch;
    logic [23:0]       plane_pitch;
    logic [ADDR_W-1:0] batch_base;
    logic              pool_layout;
  } cfg_t;

  // per-lane decode of one vector: which lanes write, plane index and offset
  typedef struct packed {
    logic [LANES-1:0]            mask;
    logic [LANES-1:0][GRP_W-1:0] plane;
    logic [LANES-1:0][OFF_W-1:0] off;
  } lane_dec_t;

  // a vector being serialized into write beats
  typedef struct packed {
    lanes_t            lanes;
    lane_dec_t         dec;
    logic [ADDR_W-1:0] base;   // row, column and batch terms
    logic [ADDR_W-1:0] step;   // address distance between planes
  } job_t;

endpackage

// File: rtl/cowa_if.sv
// ----------------------------------------------------------------------------
// cowa_if: channel interfaces of the CNN output write-back addresser
// Input vector channel, write beat channel and configuration write channel.
// ----------------------------------------------------------------------------
interface cowa_in_if;
  logic                  valid;
  logic                  ready;
  logic [cowa_pkg::LANES*cowa_pkg::DATA_BITS-1:0] lanes;

  modport source (output valid, output lanes, input ready);
  modport sink   (input valid, input lanes, output ready);
endinterface

interface cowa_out_if;
  logic                              valid;
  logic                              ready;
  logic [cowa_pkg::ADDR_W-1:0]       write_address;
  logic signed [cowa_pkg::DATA_BITS-1:0] write_data;
  logic                              last;

  modport source (output valid, output write_address, output write_data, output last,
                  input ready);
  modport sink   (input valid, input write_address, input write_data, input last,
                  output ready);
endinterface

interface cowa_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cowa_pkg::CFG_IDX_W-1:0]  index;
  logic [cowa_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/cnn_output_writeback_addresser.sv
// ----------------------------------------------------------------------------
// cnn_output_writeback_addresser: item, job and output registers lie between input beat and first write beat
// Throughput: one write beat per cycle while the receiver holds ready high.
// Reset (rst_n low, synchronous): counters zero, registers to defaults, pipeline empty.
// ----------------------------------------------------------------------------
//
// Pipeline:
//   item register  - accepted vector plus the col/row/group it belongs to;
//                    the position counters advance at the input beat.
//   job register   - lane mask, plane index and offset per lane, and the
//                    row/column/batch part of the address. A vector with no
//                    lane in range is dropped here and never becomes a job.
//   output register- one write beat; the job hands out its lowest pending lane
//                    each time the output register is free or being drained.
// The serializer's single write port sets the rate: one beat per cycle while the receiver is ready.
// The item register takes a new vector while a job is still emitting.
module cnn_output_writeback_addresser (
  input  logic             clk,
  input  logic             rst_n,
  cowa_in_if.sink          in_ch,
  cowa_out_if.source       out_ch,
  cowa_cfg_if.sink         cfg_ch
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cowa_pkg::cfg_t cfg_r;

  // no register beat is taken while in reset
  assign cfg_ch.ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width_cols    <= 8'd1;
      cfg_r.height_rows   <= 8'd1;
      cfg_r.channel_count <= 12'd1;
      cfg_r.channel_pad   <= 8'd0;
      cfg_r.row_pitch     <= 16'd1;
      cfg_r.plane_pitch   <= 24'd1;
      cfg_r.batch_base    <= '0;
      cfg_r.pool_layout   <= 1'b0;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        cowa_pkg::REG_WIDTH_COLS:    cfg_r.width_cols    <= cfg_ch.data[7:0];
        cowa_pkg::REG_HEIGHT_ROWS:   cfg_r.height_rows   <= cfg_ch.data[7:0];
        cowa_pkg::REG_CHANNEL_COUNT: cfg_r.channel_count <= cfg_ch.data[11:0];
        cowa_pkg::REG_CHANNEL_PAD:   cfg_r.channel_pad   <= cfg_ch.data[7:0];
        cowa_pkg::REG_ROW_PITCH:     cfg_r.row_pitch     <= cfg_ch.data[15:0];
        cowa_pkg::REG_PLANE_PITCH:   cfg_r.plane_pitch   <= cfg_ch.data[23:0];
        cowa_pkg::REG_BATCH_BASE:    cfg_r.batch_base    <= cfg_ch.data[31:0];
        cowa_pkg::REG_POOL_LAYOUT:   cfg_r.pool_layout   <= cfg_ch.data[0];
        default: ;  // indexes past the list are dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake control
  // --------------------------------------------------------------------------
  logic                 item_v_r, item_v_nxt;
  logic                 job_v_r, job_v_nxt;
  logic                 out_v_r, out_v_nxt;
  logic                 in_fire, item_move, beat_fire, beat_last, job_done;
  cowa_pkg::lane_dec_t  dec;
  cowa_pkg::job_t       job_r;
  logic [cowa_pkg::LANES-1:0] mask_rem;

  assign beat_fire = job_v_r && (!out_v_r || out_ch.ready);
  assign job_done  = beat_fire && beat_last;
  // item moves into the job slot when the slot is empty or empties now
  assign item_move = item_v_r && (!job_v_r || job_done);
  assign in_ch.ready = rst_n && (!item_v_r || item_move);
  assign in_fire   = in_ch.valid && in_ch.ready;

  // --------------------------------------------------------------------------
  // Position counters: column, then row, then lane group
  // --------------------------------------------------------------------------
  logic [7:0]                 col_index_r, col_index_nxt;
  logic [7:0]                 row_index_r, row_index_nxt;
  logic [cowa_pkg::GRP_W-1:0] group_index_r, group_index_nxt;
  logic [12:0]                group_span;
  logic [12:0]                group_total;

  always_comb begin
    group_span  = 13'(cfg_r.channel_count) + 13'({cfg_r.channel_pad, 1'b0});
    group_total = 13'(group_span / 13'(cowa_pkg::LANES));
    if (group_total == 13'd0) group_total = 13'd1;

    col_index_nxt   = col_index_r;
    row_index_nxt   = row_index_r;
    group_index_nxt = group_index_r;
    if (in_fire) begin
      if (({1'b0, col_index_r} + 9'd1) >= {1'b0, cfg_r.width_cols}) begin
        col_index_nxt = '0;
        if (({1'b0, row_index_r} + 9'd1) >= {1'b0, cfg_r.height_rows}) begin
          row_index_nxt = '0;
          if (({1'b0, group_index_r} + 13'd1) >= group_total) begin
            group_index_nxt = '0;
          end else begin
            group_index_nxt = group_index_r + 12'd1;
          end
        end else begin
          row_index_nxt = row_index_r + 8'd1;
        end
      end else begin
        col_index_nxt = col_index_r + 8'd1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Item register
  // --------------------------------------------------------------------------
  cowa_pkg::lanes_t           item_lanes_r;
  logic [7:0]                 item_col_r, item_row_r;
  logic [cowa_pkg::GRP_W-1:0] item_grp_r;

  assign item_v_nxt = in_fire ? 1'b1 : (item_move ? 1'b0 : item_v_r);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_lanes_r <= cowa_pkg::lanes_t'(in_ch.lanes);
      item_col_r   <= col_index_r;
      item_row_r   <= row_index_r;
      item_grp_r   <= group_index_r;
    end
  end

  // --------------------------------------------------------------------------
  // Job stage: lane decode and the address terms common to all lanes
  // --------------------------------------------------------------------------
  cowa_lane_decode u_decode (
    .cfg       (cfg_r),
    .group_idx (item_grp_r),
    .dec       (dec)
  );

  logic [cowa_pkg::ADDR_W-1:0] stride, row_term, base_nxt, step_nxt;

  always_comb begin
    stride   = cfg_r.pool_layout ? 32'(cowa_pkg::LANES) : 32'(cowa_pkg::VECTOR);
    row_term = 32'(item_row_r) * 32'(cfg_r.row_pitch);
    base_nxt = row_term * stride + 32'(item_col_r) * stride + cfg_r.batch_base;
    step_nxt = 32'(cfg_r.plane_pitch) * stride;
  end

  // lowest pending lane goes out first
  logic [cowa_pkg::LANE_W-1:0] sel;

  always_comb begin
    sel = '0;
    for (int l = cowa_pkg::LANES - 1; l >= 0; l--) begin
      if (job_r.dec.mask[l]) sel = cowa_pkg::LANE_W'(l);
    end
    mask_rem  = job_r.dec.mask & (job_r.dec.mask - 1'b1);
    beat_last = (mask_rem == '0);
  end

  always_comb begin
    job_v_nxt = job_v_r;
    if (item_move) begin
      job_v_nxt = (dec.mask != '0);
    end else if (beat_fire) begin
      job_v_nxt = !beat_last;
    end
  end

  always_ff @(posedge clk) begin
    if (item_move) begin
      job_r.lanes <= item_lanes_r;
      job_r.dec   <= dec;
      job_r.base  <= base_nxt;
      job_r.step  <= step_nxt;
    end else if (beat_fire) begin
      job_r.dec.mask <= mask_rem;
    end
  end

  // --------------------------------------------------------------------------
  // Output register: one write beat
  // --------------------------------------------------------------------------
  logic [cowa_pkg::ADDR_W-1:0]           out_addr_r, addr_nxt;
  logic signed [cowa_pkg::DATA_BITS-1:0] out_data_r;
  logic                                  out_last_r;

  assign addr_nxt  = 32'(job_r.dec.plane[sel]) * job_r.step + job_r.base
                   + 32'(job_r.dec.off[sel]);
  assign out_v_nxt = beat_fire ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (beat_fire) begin
      out_addr_r <= addr_nxt;
      out_data_r <= signed'(job_r.lanes[sel]);
      out_last_r <= beat_last;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.write_address = out_addr_r;
  assign out_ch.write_data    = out_data_r;
  assign out_ch.last          = out_last_r;

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_v_r      <= 1'b0;
      job_v_r       <= 1'b0;
      out_v_r       <= 1'b0;
      col_index_r   <= '0;
      row_index_r   <= '0;
      group_index_r <= '0;
    end else begin
      item_v_r      <= item_v_nxt;
      job_v_r       <= job_v_nxt;
      out_v_r       <= out_v_nxt;
      col_index_r   <= col_index_nxt;
      row_index_r   <= row_index_nxt;
      group_index_r <= group_index_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_job_has_lanes: assert property (@(posedge clk) disable iff (!rst_n)
    job_v_r |-> (job_r.dec.mask != '0))
    else $error("job slot valid with no pending lane");

  a_item_holds: assert property (@(posedge clk) disable iff (!rst_n)
    item_v_r && !item_move |=> item_v_r && $stable(item_lanes_r))
    else $error("waiting vector lost or overwritten");

  a_last_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_done && !item_move |=> !job_v_r)
    else $error("job still active after its last beat");

  a_last_beat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    beat_fire |=> out_v_r && (out_last_r == $past(beat_last)))
    else $error("last flag does not match pending lanes");

endmodule

// File: rtl/cowa_lane_decode.sv
// ----------------------------------------------------------------------------
// cowa_lane_decode: per-lane channel range check and plane/offset split
// Forms z = group*LANES + lane, keeps lanes with pad <= z < pad + count.
// ----------------------------------------------------------------------------
module cowa_lane_decode (
  input  cowa_pkg::cfg_t                  cfg,
  input  logic [cowa_pkg::GRP_W-1:0]      group_idx,
  output cowa_pkg::lane_dec_t             dec
);

  always_comb begin
    logic [15:0] z;
    logic [15:0] c;
    dec = '0;
    for (int l = 0; l < cowa_pkg::LANES; l++) begin
      z = 16'(32'(group_idx) * 32'(cowa_pkg::LANES) + 32'(l));
      c = z - 16'(cfg.channel_pad);
      dec.mask[l] = (z >= 16'(cfg.channel_pad)) && (c < 16'(cfg.channel_count));
      if (cfg.pool_layout) begin
        dec.plane[l] = group_idx;
        dec.off[l]   = cowa_pkg::OFF_W'(l);
      end else begin
        dec.plane[l] = cowa_pkg::GRP_W'(c / 16'(cowa_pkg::VECTOR));
        dec.off[l]   = cowa_pkg::OFF_W'(c % 16'(cowa_pkg::VECTOR));
      end
    end
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench of the CNN output write-back addresser
// Streams lane vectors through the block under a mix of layer settings and
// checks every write beat (address, data, last) against a cycle-free predictor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CLK_HALF     = 10;      // 20 ns period
  localparam int RESET_CYCLES = 9;
  localparam int IDLE_TAIL    = 12;      // leave room for stray beats
  localparam int RANDOM_ITEMS = 300;
  localparam int CYCLE_LIMIT  = 400000;  // far beyond the slowest legal run

  // receiver stall patterns, taken in turn
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  // one expected write beat
  typedef struct packed {
    logic [cowa_pkg::ADDR_W-1:0]    address;
    logic [cowa_pkg::DATA_BITS-1:0] data;
    logic                           last;
  } write_t;

  // --------------------------------------------------------------------------
  // Predictor and store of expected writes. Keeps its own register file and
  // position counters; both are updated at the beat that changes them.
  // --------------------------------------------------------------------------
  class writeback_predictor;
    cowa_pkg::cfg_t regs;
    logic [7:0]     col;
    logic [7:0]     row;
    logic [11:0]    grp;
    write_t         pending_writes[$];
    int             errors;
    int             writes_checked;
    int             silent_vectors;

    function new();
      regs.width_cols    = 8'd1;
      regs.height_rows   = 8'd1;
      regs.channel_count = 12'd1;
      regs.channel_pad   = 8'd0;
      regs.row_pitch     = 16'd1;
      regs.plane_pitch   = 24'd1;
      regs.batch_base    = '0;
      regs.pool_layout   = 1'b0;
      col = '0;
      row = '0;
      grp = '0;
      errors = 0;
      writes_checked = 0;
      silent_vectors = 0;
    endfunction

    // register beat; each value is cut to its field width
    function void set_reg(logic [cowa_pkg::CFG_IDX_W-1:0]  idx,
                          logic [cowa_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        cowa_pkg::REG_WIDTH_COLS:    regs.width_cols    = data[7:0];
        cowa_pkg::REG_HEIGHT_ROWS:   regs.height_rows   = data[7:0];
        cowa_pkg::REG_CHANNEL_COUNT: regs.channel_count = data[11:0];
        cowa_pkg::REG_CHANNEL_PAD:   regs.channel_pad   = data[7:0];
        cowa_pkg::REG_ROW_PITCH:     regs.row_pitch     = data[15:0];
        cowa_pkg::REG_PLANE_PITCH:   regs.plane_pitch   = data[23:0];
        cowa_pkg::REG_BATCH_BASE:    regs.batch_base    = data;
        cowa_pkg::REG_POOL_LAYOUT:   regs.pool_layout   = data[0];
        default: ;  // unused index: no effect
      endcase
    endfunction

    // accepted input vector: queue the writes it causes, then step counters
    function void take_vector(cowa_pkg::lanes_t lanes);
      int unsigned z, c, addr, groups;
      int unsigned cnt, pad, width, height, colv, rowv, grpv, rp, pp;
      int          n;
      write_t      w;
      cnt    = regs.channel_count;
      pad    = regs.channel_pad;
      width  = regs.width_cols;
      height = regs.height_rows;
      rp     = regs.row_pitch;
      pp     = regs.plane_pitch;
      colv   = col;
      rowv   = row;
      grpv   = grp;
      n = 0;
      for (int l = 0; l < cowa_pkg::LANES; l++) begin
        z = grpv * cowa_pkg::LANES + l;
        if (z < pad) continue;
        c = z - pad;
        if (c >= cnt) continue;
        if (regs.pool_layout) begin
          addr = grpv * pp * cowa_pkg::LANES + rowv * rp * cowa_pkg::LANES
               + colv * cowa_pkg::LANES + l;
        end else begin
          addr = (c / cowa_pkg::VECTOR) * pp * cowa_pkg::VECTOR
               + rowv * rp * cowa_pkg::VECTOR + colv * cowa_pkg::VECTOR
               + (c % cowa_pkg::VECTOR);
        end
        w.address = addr + regs.batch_base;  // wraps at 32 bits
        w.data    = lanes[l];
        w.last    = 1'b0;
        pending_writes.push_back(w);
        n++;
      end
      if (n > 0) pending_writes[pending_writes.size()-1].last = 1'b1;
      else silent_vectors++;

      // column, then row, then lane group; a zero size acts as one
      groups = (cnt + 2 * pad) / cowa_pkg::LANES;
      if (groups == 0) groups = 1;
      if (colv + 1 >= width) begin
        col = '0;
        if (rowv + 1 >= height) begin
          row = '0;
          if (grpv + 1 >= groups) grp = '0;
          else grp = grp + 12'd1;
        end else begin
          row = row + 8'd1;
        end
      end else begin
        col = col + 8'd1;
      end
    endfunction

    // accepted write beat against the oldest expectation
    function void check_write(logic [cowa_pkg::ADDR_W-1:0]    addr,
                              logic [cowa_pkg::DATA_BITS-1:0] data,
                              logic                           last);
      write_t w;
      writes_checked++;
      if (pending_writes.size() == 0) begin
        errors++;
        $error("unexpected write beat: write_address %h write_data %h last %b",
               addr, data, last);
        return;
      end
      w = pending_writes.pop_front();
      if (w.address !== addr) begin
        errors++;
        $error("write_address: expected %h, actual %h", w.address, addr);
      end
      if (w.data !== data) begin
        errors++;
        $error("write_data: expected %h, actual %h", w.data, data);
      end
      if (w.last !== last) begin
        errors++;
        $error("last: expected %b, actual %b", w.last, last);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  int   cycles = 0;
  int   vectors_sent = 0;
  int   config_sets = 0;

  always #(CLK_HALF) clk = ~clk;

  cowa_in_if  in_bus ();
  cowa_out_if out_bus ();
  cowa_cfg_if cfg_bus ();

  writeback_predictor pred = new();

  cnn_output_writeback_addresser u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus),
    .cfg_ch (cfg_bus)
  );

  // every block input starts at a known value
  initial begin
    in_bus.valid  = 1'b0;
    in_bus.lanes  = '0;
    out_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = '0;
    cfg_bus.data  = '0;
  end

  // --------------------------------------------------------------------------
  // Monitors: sample at the rising edge, before the block's own updates land
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && cfg_bus.valid && cfg_bus.ready === 1'b1)
      pred.set_reg(cfg_bus.index, cfg_bus.data);
    if (rst_n && in_bus.valid && in_bus.ready === 1'b1)
      pred.take_vector(cowa_pkg::lanes_t'(in_bus.lanes));
    if (rst_n && out_bus.valid === 1'b1 && out_bus.ready)
      pred.check_write(out_bus.write_address, out_bus.write_data, out_bus.last);
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d writes still expected",
               cycles, pred.pending_writes.size());
      $display("[cnn_output_writeback_addresser] ERROR");
      $finish;
    end
  end

  // receiver: open, coin-flip, sparse and long-block stall patterns in turn
  always @(negedge clk) begin
    case (rx_mode_t'((cycles / 97) % 4))
      RX_OPEN:   out_bus.ready = 1'b1;
      RX_COIN:   out_bus.ready = 1'($urandom_range(0, 1));
      RX_SPARSE: out_bus.ready = ($urandom_range(0, 3) == 0);
      RX_BLOCKS: out_bus.ready = ((cycles % 16) >= 10);
      default:   out_bus.ready = 1'b1;
    endcase
  end

  // --------------------------------------------------------------------------
  // Drivers: all called at a falling edge, return at a falling edge
  // --------------------------------------------------------------------------

  // one vector beat; valid is left high so a burst can follow without a gap
  task automatic push_vector(cowa_pkg::lanes_t v);
    in_bus.valid = 1'b1;
    in_bus.lanes = v;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    vectors_sent++;
    @(negedge clk);
  endtask

  // one register beat; bits above the field carry junk the block must drop
  task automatic cfg_beat(logic [cowa_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value,
                          int bits);
    logic [31:0] junk;
    junk = $urandom();
    cfg_bus.index = idx;
    cfg_bus.data  = (junk << bits) | value;
    cfg_bus.valid = 1'b1;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // whole register file, back to back; now and then a beat to an unused index
  task automatic set_config(cowa_pkg::cfg_t c);
    cfg_beat(cowa_pkg::REG_WIDTH_COLS,    32'(c.width_cols),    8);
    cfg_beat(cowa_pkg::REG_HEIGHT_ROWS,   32'(c.height_rows),   8);
    cfg_beat(cowa_pkg::REG_CHANNEL_COUNT, 32'(c.channel_count), 12);
    cfg_beat(cowa_pkg::REG_CHANNEL_PAD,   32'(c.channel_pad),   8);
    cfg_beat(cowa_pkg::REG_ROW_PITCH,     32'(c.row_pitch),     16);
    cfg_beat(cowa_pkg::REG_PLANE_PITCH,   32'(c.plane_pitch),   24);
    cfg_beat(cowa_pkg::REG_BATCH_BASE,    c.batch_base,         32);
    cfg_beat(cowa_pkg::REG_POOL_LAYOUT,   32'(c.pool_layout),   1);
    if ($urandom_range(0, 1) == 0)
      cfg_beat(cowa_pkg::CFG_IDX_W'(cowa_pkg::REG_POOL_LAYOUT + $urandom_range(1, 8)),
               $urandom(), 32);
    cfg_bus.valid = 1'b0;
    config_sets++;
  endtask

  // all expected writes in, then a tail for vectors that emit nothing
  task automatic wait_idle();
    in_bus.valid = 1'b0;
    while (pred.pending_writes.size() != 0) @(negedge clk);
    repeat (IDLE_TAIL) @(negedge clk);
  endtask

  function automatic cowa_pkg::cfg_t make_cfg(int unsigned w, int unsigned h,
                                              int unsigned cnt, int unsigned pad,
                                              int unsigned rp, int unsigned pp,
                                              logic [31:0] base, logic pool);
    cowa_pkg::cfg_t c;
    c.width_cols    = w[7:0];
    c.height_rows   = h[7:0];
    c.channel_count = cnt[11:0];
    c.channel_pad   = pad[7:0];
    c.row_pitch     = rp[15:0];
    c.plane_pitch   = pp[23:0];
    c.batch_base    = base;
    c.pool_layout   = pool;
    return c;
  endfunction

  // low, high or random
  function automatic int unsigned pick(int unsigned lo, int unsigned hi,
                                       int unsigned any);
    case ($urandom_range(0, 2))
      0:       return lo;
      1:       return hi;
      default: return any;
    endcase
  endfunction

  function automatic cowa_pkg::lanes_t random_lanes();
    cowa_pkg::lanes_t v;
    case ($urandom_range(0, 9))
      0: v = '0;
      1: v = '1;
      2: for (int l = 0; l < cowa_pkg::LANES; l++)
           v[l] = $urandom_range(0, 1) ? 8'h80 : 8'h7F;
      default: v = {$urandom(), $urandom()};
    endcase
    return v;
  endfunction

  // random burst/gap sender; rare full drains put pressure on the pipeline
  task automatic run_vectors(int count);
    int  sent, burst, gap;
    bit  tight;
    sent  = 0;
    tight = ($urandom_range(0, 3) == 0);  // whole phase without gaps
    while (sent < count) begin
      burst = $urandom_range(1, 8);
      repeat (burst) begin
        if (sent < count) begin
          push_vector(random_lanes());
          sent++;
        end
      end
      if ($urandom_range(0, 29) == 0) begin
        in_bus.valid = 1'b0;
        while (pred.pending_writes.size() != 0) @(negedge clk);
      end else if (!tight) begin
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
          in_bus.valid = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
    in_bus.valid = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  localparam logic [63:0] PATTERNS [6] = '{
    64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'h8080_8080_8080_8080,
    64'h7F7F_7F7F_7F7F_7F7F, 64'h0123_4567_89AB_CDEF, 64'hAA55_AA55_55AA_55AA
  };

  initial begin
    int rand_sent, n;

    rst_n = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset settings: one channel, so only lane 0 of each vector writes
    foreach (PATTERNS[i]) push_vector(cowa_pkg::lanes_t'(PATTERNS[i]));
    wait_idle();

    // 20 channels behind 3 pad channels over 3 groups: partial first and last
    // groups, a full middle group, last marked on a lane below the top
    set_config(make_cfg(1, 2, 20, 3, 5, 7, 32'h100, 1'b0));
    foreach (PATTERNS[i]) push_vector(cowa_pkg::lanes_t'(PATTERNS[i]));
    wait_idle();

    // same geometry, lane-interleaved layout
    set_config(make_cfg(1, 2, 20, 3, 5, 7, 32'h100, 1'b1));
    foreach (PATTERNS[i]) push_vector(cowa_pkg::lanes_t'(PATTERNS[i]));
    wait_idle();

    // largest sizes and pitches, base at the top: address wraps at 32 bits
    set_config(make_cfg(255, 255, 4095, 0, 16'hFFFF, 24'hFF_FFFF, 32'hFFFF_FFFF, 1'b0));
    for (int i = 1; i < 4; i++) push_vector(cowa_pkg::lanes_t'(PATTERNS[i]));
    wait_idle();

    // zero sizes and no channels: nothing is written, counters still move
    set_config(make_cfg(0, 0, 0, 0, 0, 0, 32'h0, 1'b1));
    for (int i = 0; i < 2; i++) push_vector(cowa_pkg::lanes_t'(PATTERNS[i + 4]));
    wait_idle();

    // widest pad: 31 silent groups, one lone top lane, one full group, then
    // silent groups up to the wrap of the group counter
    set_config(make_cfg(1, 1, 9, 255, 3, 11, $urandom(), 1'b0));
    run_vectors(70);
    wait_idle();
    rand_sent = 70;

    // random layers: mostly small shapes, some at the extremes
    while (rand_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        set_config(make_cfg(pick(0, 255, $urandom_range(0, 255)),
                            pick(0, 255, $urandom_range(0, 255)),
                            pick(0, 4095, $urandom_range(0, 4095)),
                            pick(0, 255, $urandom_range(0, 255)),
                            pick(0, 16'hFFFF, $urandom_range(0, 16'hFFFF)),
                            pick(0, 24'hFF_FFFF, $urandom_range(0, 24'hFF_FFFF)),
                            pick(0, 32'hFFFF_FFFF, $urandom()),
                            1'($urandom_range(0, 1))));
      end else begin
        set_config(make_cfg($urandom_range(0, 4), $urandom_range(0, 3),
                            $urandom_range(0, 40), $urandom_range(0, 12),
                            $urandom_range(0, 16'hFFFF), $urandom_range(0, 24'hFF_FFFF),
                            $urandom(), 1'($urandom_range(0, 1))));
      end
      n = $urandom_range(20, 50);
      run_vectors(n);
      rand_sent += n;
      wait_idle();
    end

    $display("covered %0d vectors (%0d with no write) and %0d write beats",
             vectors_sent, pred.silent_vectors, pred.writes_checked);
    $display("over %0d register sets, both layouts, sizes from zero to full scale",
             config_sets);
    if (pred.errors == 0) begin
      $display("[cnn_output_writeback_addresser] OK");
    end else begin
      $display("%0d mismatches", pred.errors);
      $display("[cnn_output_writeback_addresser] ERROR");
    end
    $finish;
  end

endmodule
